### hw/rtl/sorted_insert_priority_queue_macros.svh
// assertion macros for the sorted insert priority queue
// expects clk and rst in the scope where the macros are used
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SIPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define SIPQ_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### hw/rtl/sipq_pkg.sv
// shared types and codes for the sorted insert priority queue
// no dependencies
`default_nettype none

package sipq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int PRIO_W          = 8;
  localparam int STATUS_W        = 2;
  localparam int OCC_W           = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PLACE,
    S_TAKE_RD,
    S_TAKE_FRONT,
    S_TAKE_SHIFT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_insert_priority_queue.sv
// Sorted priority queue of (id, priority) task entries, lowest priority value at the front,
// newest first among equal priorities. Entries sit in a single-port-write, registered-read
// memory that one priority comparator walks one entry per cycle. An insert into an empty
// queue is written at once; otherwise the walk moves each entry with a priority value >= the
// new one back one slot, then writes the new entry. A take returns the front entry and moves
// the rest up one slot; a dropped insert or a take on empty goes straight to the result. One
// transaction is worked on at a time and s_tready is low meanwhile; a finished result waits
// in the output register while the next transaction is accepted. No clearing pass follows
// reset. Depends on sipq_pkg and sorted_insert_priority_queue_macros.svh.
`default_nettype none

module sorted_insert_priority_queue #(
  parameter int QUEUE_DEPTH = sipq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // task_id[15:0], task_priority[23:16]
  input  logic        s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // out_id[15:0], out_priority[23:16], status[25:24],
                                 // occupancy[30:26], zero[31]
);

  import sipq_pkg::*;

  `include "sorted_insert_priority_queue_macros.svh"

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  state_t state, state_next;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  entry_t          wr_data;

  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [ID_W-1:0]     new_id;
  logic [PRIO_W-1:0]   new_prio;
  logic [ID_W-1:0]     res_id;
  logic [PRIO_W-1:0]   res_prio;
  logic [STATUS_W-1:0] res_status;

  logic          in_op;
  logic          accept;
  logic          hit;
  logic          is_full, is_empty;
  logic          shift_last;
  logic          out_load;
  logic [CW-1:0] count_m1;
  entry_t        new_entry;

  assign in_op      = s_tuser;
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign is_full    = (count == DEPTH_CNT);
  assign is_empty   = (count == '0);
  assign count_m1   = count - CW'(1);
  assign hit        = (new_prio <= rdata.prio);
  assign shift_last = (CW'(idx) == count_m1);
  assign out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
  assign new_entry  = '{id: new_id, prio: new_prio};

  // entry store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_TAKE) begin
            state_next = is_empty ? S_DONE : S_TAKE_RD;
          end else if (is_full) begin
            state_next = S_DONE;
          end else begin
            state_next = is_empty ? S_INS_PLACE : S_INS_RD;
          end
        end
      end
      S_INS_RD:     state_next = S_INS_CMP;
      S_INS_CMP: begin
        if (!hit) begin
          state_next = S_DONE;
        end else if (idx == '0) begin
          state_next = S_INS_PLACE;
        end
      end
      S_INS_PLACE:  state_next = S_DONE;
      S_TAKE_RD:    state_next = S_TAKE_FRONT;
      S_TAKE_FRONT: state_next = (count == CW'(1)) ? S_DONE : S_TAKE_SHIFT;
      S_TAKE_SHIFT: begin
        if (shift_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = new_entry;
    case (state)
      S_INS_RD: begin
        rd_en = 1'b1;
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx + AW'(1);
        if (hit) begin
          wr_data = rdata;
          if (idx != '0) begin
            rd_en   = 1'b1;
            rd_addr = idx - AW'(1);
          end
        end
      end
      S_INS_PLACE: begin
        wr_en = 1'b1;
      end
      S_TAKE_RD: begin
        rd_en = 1'b1;
      end
      S_TAKE_FRONT: begin
        if (count != CW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
        end
      end
      S_TAKE_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx - AW'(1);
        wr_data = rdata;
        if (!shift_last) begin
          rd_en   = 1'b1;
          rd_addr = idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_INS_CMP: begin
          if (!hit) begin
            count <= count + CW'(1);
          end
        end
        S_INS_PLACE:  count <= count + CW'(1);
        S_TAKE_FRONT: begin
          if (count == CW'(1)) begin
            count <= count_m1;
          end
        end
        S_TAKE_SHIFT: begin
          if (shift_last) begin
            count <= count_m1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk index and result staging
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          new_id   <= s_tdata[15:0];
          new_prio <= s_tdata[23:16];
          res_id   <= '0;
          res_prio <= '0;
          if (in_op == OP_TAKE) begin
            idx        <= '0;
            res_status <= is_empty ? ST_EMPTY : ST_TAKEN;
          end else begin
            idx        <= is_empty ? '0 : AW'(count_m1);
            res_status <= is_full ? ST_FULL : ST_INSERTED;
          end
        end
      end
      S_INS_CMP: begin
        if (hit && idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      S_TAKE_FRONT: begin
        res_id   <= rdata.id;
        res_prio <= rdata.prio;
        idx      <= AW'(1);
      end
      S_TAKE_SHIFT: begin
        if (!shift_last) begin
          idx <= idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, OCC_W'(count), res_status, res_prio, res_id};
    end
  end

  `SIPQ_ASSERT(a_count_bound, count <= DEPTH_CNT, "entry count above queue depth")
  `SIPQ_ASSERT(a_count_at_end, (count != $past(count)) |-> (state == S_DONE),
               "entry count changed outside the end of a transaction")
  `SIPQ_ASSERT(a_insert_nonempty, (state == S_DONE && res_status == ST_INSERTED) |-> !is_empty,
               "insert reported with an empty queue")
  `SIPQ_ASSERT_NEXT(a_shift_in_range, state == S_TAKE_SHIFT,
                    (state == S_TAKE_SHIFT) ? (CW'(idx) < count) : 1'b1,
                    "take shift index beyond stored entries")

endmodule

`default_nettype wire

### verif/sipq_result_monitor.sv
// result monitor for the sorted insert priority queue: predicts every result and compares it
// with what leaves the master side; depends on sipq_pkg
`default_nettype none

module sipq_result_monitor #(
  parameter int DEPTH = sipq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // task_id[15:0], task_priority[23:16]
  input  logic        s_tuser,   // op[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // out_id[15:0], out_priority[23:16], status[25:24],
                                 // occupancy[30:26], zero[31]
  output int          errors,
  output int          outstanding,
  output int          n_inserted,
  output int          n_taken,
  output int          n_dropped,
  output int          n_empty_takes,
  output int          peak_occupancy
);
  import sipq_pkg::*;

  // packed in the same order as m_tdata[30:0]
  typedef struct packed {
    logic [OCC_W-1:0]    occ;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     id;
  } result_t;

  entry_t  ready_slots [DEPTH];
  int      ready_count;
  result_t expected_results [$];

  // one queue operation on the shadow copy, returning the result it must produce
  function automatic result_t ready_queue_step(logic op, logic [ID_W-1:0] id,
                                               logic [PRIO_W-1:0] prio);
    result_t r;
    int      pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (ready_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = ready_count;
        // first stored entry with priority >= new one, so ties put the newest in front
        for (int j = 0; j < ready_count; j++) begin
          if (pos == ready_count && prio <= ready_slots[j].prio) pos = j;
        end
        for (int j = ready_count; j > pos; j--) ready_slots[j] = ready_slots[j-1];
        ready_slots[pos].id   = id;
        ready_slots[pos].prio = prio;
        ready_count++;
        r.status = ST_INSERTED;
      end
    end else if (ready_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.id   = ready_slots[0].id;
      r.prio = ready_slots[0].prio;
      for (int j = 1; j < ready_count; j++) ready_slots[j-1] = ready_slots[j];
      ready_count--;
      r.status = ST_TAKEN;
    end
    r.occ = OCC_W'(ready_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      ready_count = 0;
      expected_results.delete();
      errors = 0;
      n_inserted = 0;
      n_taken = 0;
      n_dropped = 0;
      n_empty_takes = 0;
      peak_occupancy = 0;
    end else begin
      // a result always belongs to an earlier transaction, so compare before predicting
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          got  = m_tdata[30:0];
          check_field("out_id", want.id, got.id);
          check_field("out_priority", 16'(want.prio), 16'(got.prio));
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("occupancy", 16'(want.occ), 16'(got.occ));
          check_field("pad bit", 16'h0, 16'(m_tdata[31]));
        end
      end
      if (s_tvalid && s_tready) begin
        want = ready_queue_step(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        expected_results.push_back(want);
        case (want.status)
          ST_TAKEN:    n_taken++;
          ST_INSERTED: n_inserted++;
          ST_FULL:     n_dropped++;
          default:     n_empty_takes++;
        endcase
        if (ready_count > peak_occupancy) peak_occupancy = ready_count;
      end
    end
    outstanding = expected_results.size();
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// testbench top for the sorted insert priority queue: drives directed and random transactions
// with bursty input and stalling output; depends on sipq_pkg and sipq_result_monitor
`default_nettype none

module tb_top;
  import sipq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = OP_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int errors, outstanding, n_inserted, n_taken, n_dropped, n_empty_takes, peak_occupancy;
  int items_sent = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  sorted_insert_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH_DEF)) dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  sipq_result_monitor #(.DEPTH(QUEUE_DEPTH_DEF)) monitor (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .errors, .outstanding, .n_inserted, .n_taken, .n_dropped, .n_empty_takes,
    .peak_occupancy
  );

  // offer one transaction from a falling edge; after acceptance, between bursts, drop valid for a random gap
  task automatic offer_item(input logic op, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio);
    s_tuser  = op;
    s_tdata  = {prio, id};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin : stimulus
    int insert_pct;
    int prio_max;
    logic op;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // take on empty, extreme fields, equal priorities, drain past empty, then fill past full and take
    offer_item(OP_TAKE, 16'hffff, 8'hff);
    offer_item(OP_INSERT, 16'hffff, 8'hff);
    offer_item(OP_INSERT, 16'h0000, 8'h00);
    offer_item(OP_INSERT, 16'h1234, 8'h80);
    offer_item(OP_INSERT, 16'habcd, 8'h80);
    offer_item(OP_INSERT, 16'h5555, 8'h00);
    offer_item(OP_INSERT, 16'haaaa, 8'h7f);
    repeat (7) offer_item(OP_TAKE, 16'($urandom), 8'($urandom));
    for (int k = 0; k < 17; k++) offer_item(OP_INSERT, 16'($urandom), 8'($urandom_range(0, 3)));
    offer_item(OP_TAKE, 16'h0000, 8'h00);

    insert_pct = 50;
    prio_max   = 255;
    for (int k = 0; k < 1200; k++) begin
      // change the fill or drain bias and the priority spread every so often
      if (k % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 85;
          1: insert_pct = 15;
          2: insert_pct = 50;
          default: insert_pct = 65;
        endcase
        case ($urandom_range(0, 2))
          0: prio_max = 3;
          1: prio_max = 31;
          default: prio_max = 255;
        endcase
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_TAKE;
      offer_item(op, 16'($urandom), 8'($urandom_range(0, prio_max)));
    end
    s_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d transactions: %0d inserts, %0d takes, peak occupancy %0d",
             items_sent, n_inserted, n_taken, peak_occupancy);
    $display("  %0d inserts dropped on a full queue, %0d takes from an empty queue",
             n_dropped, n_empty_takes);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: segments of random readiness, plus one long hold-off to back up the input
  initial begin : receiver
    int seg_len;
    int ready_pct;
    bit held_off;
    held_off = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
      repeat (seg_len) begin
        if (!held_off && items_sent >= 300) begin
          m_tready = 1'b0;
          repeat (250) @(negedge clk);
          held_off = 1'b1;
        end
        m_tready = ($urandom_range(0, 99) < ready_pct);
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
